FILE: sv/rsz_pkg.sv
package rsz_pkg;

   localparam int DEF_MAX_IN_WIDTH  = 1024;
   localparam int DEF_MAX_IN_HEIGHT = 128;
   localparam int DEF_MAX_OUT_SIDE  = 1024;

   localparam int CHANNELS    = 3;
   localparam int PIX_W       = CHANNELS * 8;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [25:0] STEP_RESET = 26'd65536;

   typedef enum logic [2:0] {
      CSR_IN_WIDTH,
      CSR_IN_HEIGHT,
      CSR_OUT_WIDTH,
      CSR_OUT_HEIGHT,
      CSR_X_STEP,
      CSR_Y_STEP
   } csr_index_type;

   typedef struct packed {
      logic [10:0] in_width;
      logic [7:0]  in_height;
      logic [10:0] out_width;
      logic [10:0] out_height;
      logic [25:0] x_step;
      logic [25:0] y_step;
   } cfg_type;

   // flags, two source rows, two source columns, two fractions, one pixel
   function automatic int entry_width(input int xw, input int yw);
      return 3 + 2 * yw + 2 * xw + 32 + PIX_W;
   endfunction

endpackage

FILE: sv/rsz_ram.sv
module rsz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/rsz_fifo.sv
module rsz_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/rsz_front.sv
module rsz_front #(
   parameter int MAX_IN_WIDTH  = rsz_pkg::DEF_MAX_IN_WIDTH,
   parameter int MAX_IN_HEIGHT = rsz_pkg::DEF_MAX_IN_HEIGHT,
   parameter int MAX_OUT_SIDE  = rsz_pkg::DEF_MAX_OUT_SIDE,
   parameter int ENTRY_W       = rsz_pkg::entry_width($clog2(MAX_IN_WIDTH),
                                                      $clog2(MAX_IN_HEIGHT))
) (
   input  logic                clock,
   input  logic                reset,
   input  rsz_pkg::cfg_type    cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [9:0]          req_row,
   input  logic [9:0]          req_col,
   input  logic [7:0]          req_blue,
   input  logic [7:0]          req_green,
   input  logic [7:0]          req_red,
   output logic                push_valid,
   input  logic                push_ready,
   output logic [ENTRY_W-1:0]  push_data
);

   localparam int XW = $clog2(MAX_IN_WIDTH);
   localparam int YW = $clog2(MAX_IN_HEIGHT);

   typedef struct packed {
      logic                      is_read;
      logic                      in_range;
      logic                      second;
      logic [YW-1:0]             r0;
      logic [YW-1:0]             r1;
      logic [XW-1:0]             ca;
      logic [XW-1:0]             cb;
      logic [15:0]               dx;
      logic [15:0]               dy;
      logic [rsz_pkg::PIX_W-1:0] pixel;
   } entry_type;

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_mode_ff;
   logic [9:0]                s1_row_ff, s1_col_ff;
   logic [rsz_pkg::PIX_W-1:0] s1_pix_ff;
   logic [35:0]               s1_sx_ff, s1_sy_ff, sx_in, sy_in;

   logic [XW-1:0]  inw_m1, ca_calc, cb_calc;
   logic [YW-1:0]  inh_m1, r0_calc, r1_calc;
   logic [10:0]    outw, outh, row11, col11;
   logic [19:0]    ix, iy;
   logic           in_range, load_ok, hcopy, second, needs_push, s1_done, accept;
   entry_type      ent;

   assign accept = req_valid && req_ready;
   assign sx_in  = req_col * cfg.x_step;
   assign sy_in  = req_row * cfg.y_step;

   // effective sizes
   assign inw_m1 = (cfg.in_width == '0) ? '0 :
                   (32'(cfg.in_width) > MAX_IN_WIDTH) ? XW'(MAX_IN_WIDTH - 1) :
                   XW'(cfg.in_width - 11'd1);
   assign inh_m1 = (cfg.in_height == '0) ? '0 :
                   (32'(cfg.in_height) > MAX_IN_HEIGHT) ? YW'(MAX_IN_HEIGHT - 1) :
                   YW'(cfg.in_height - 8'd1);
   assign outw = (32'(cfg.out_width) > MAX_OUT_SIDE) ? 11'(MAX_OUT_SIDE) : cfg.out_width;
   assign outh = (32'(cfg.out_height) > MAX_OUT_SIDE) ? 11'(MAX_OUT_SIDE) : cfg.out_height;

   assign row11 = 11'(s1_row_ff);
   assign col11 = 11'(s1_col_ff);

   assign in_range = (row11 < outh) && (col11 < outw);
   assign load_ok  = (32'(s1_row_ff) <= 32'(inh_m1)) && (32'(s1_col_ff) <= 32'(inw_m1));
   assign hcopy    = (col11 + 11'd1 == outw) || (inw_m1 == '0);
   assign second   = !((row11 + 11'd1 == outh) || (inh_m1 == '0));

   // source indices saturate at the last column or row
   assign ix      = s1_sx_ff[35:16];
   assign iy      = s1_sy_ff[35:16];
   assign ca_calc = (ix > 20'(inw_m1)) ? inw_m1 : ix[XW-1:0];
   assign cb_calc = (ix >= 20'(inw_m1)) ? inw_m1 : ix[XW-1:0] + XW'(1);
   assign r0_calc = (iy > 20'(inh_m1)) ? inh_m1 : iy[YW-1:0];
   assign r1_calc = (iy >= 20'(inh_m1)) ? inh_m1 : iy[YW-1:0] + YW'(1);

   always_comb begin
      ent          = '0;
      ent.is_read  = s1_mode_ff;
      ent.pixel    = s1_pix_ff;
      if (s1_mode_ff) begin
         ent.in_range = in_range;
         ent.second   = second;
         ent.r0       = r0_calc;
         ent.r1       = r1_calc;
         ent.dy       = s1_sy_ff[15:0];
         if (hcopy) begin
            ent.ca = inw_m1;
            ent.cb = inw_m1;
            ent.dx = '0;
         end else begin
            ent.ca = ca_calc;
            ent.cb = cb_calc;
            ent.dx = s1_sx_ff[15:0];
         end
      end else begin
         ent.r0 = YW'(s1_row_ff);
         ent.ca = XW'(s1_col_ff);
      end
   end

   assign needs_push  = s1_mode_ff || load_ok;
   assign push_valid  = s1_valid_ff && needs_push;
   assign push_data   = ent;
   assign s1_done     = s1_valid_ff && (push_ready || !needs_push);
   assign req_ready   = !s1_valid_ff || s1_done;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff <= req_mode;
         s1_row_ff  <= req_row;
         s1_col_ff  <= req_col;
         s1_pix_ff  <= {req_red, req_green, req_blue};
         s1_sx_ff   <= sx_in;
         s1_sy_ff   <= sy_in;
      end
   end

endmodule

FILE: sv/rsz_back.sv
module rsz_back #(
   parameter int MAX_IN_WIDTH  = rsz_pkg::DEF_MAX_IN_WIDTH,
   parameter int MAX_IN_HEIGHT = rsz_pkg::DEF_MAX_IN_HEIGHT,
   parameter int ENTRY_W       = rsz_pkg::entry_width($clog2(MAX_IN_WIDTH),
                                                      $clog2(MAX_IN_HEIGHT))
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  logic [ENTRY_W-1:0] pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_blue,
   output logic [7:0]         rsp_out_green,
   output logic [7:0]         rsp_out_red,
   output logic               rsp_in_range
);

   localparam int XW = $clog2(MAX_IN_WIDTH);
   localparam int YW = $clog2(MAX_IN_HEIGHT);
   localparam int AW = $clog2(MAX_IN_WIDTH * MAX_IN_HEIGHT);
   localparam int PW = rsz_pkg::PIX_W;

   typedef struct packed {
      logic          is_read;
      logic          in_range;
      logic          second;
      logic [YW-1:0] r0;
      logic [YW-1:0] r1;
      logic [XW-1:0] ca;
      logic [XW-1:0] cb;
      logic [15:0]   dx;
      logic [15:0]   dy;
      logic [PW-1:0] pixel;
   } entry_type;

   typedef enum logic [2:0] {S_IDLE, S_B0, S_A1, S_B1, S_H1, S_V} state_type;

   state_type     state_ff;
   entry_type     head, ent_ff;
   logic [PW-1:0] p0_ff, h0_ff, h1_ff, rsp_pix_ff;
   logic          rsp_valid_ff, rsp_in_range_ff;
   logic [PW-1:0] ram_rdata, hb, vb;
   logic [AW-1:0] ram_addr;
   logic [YW-1:0] rsel;
   logic [XW-1:0] csel;
   logic          ram_we;
   logic [16:0]   wy;

   function automatic logic [7:0] hblend(input logic [7:0] a, input logic [7:0] b,
                                         input logic [15:0] f);
      logic [16:0] w;
      logic [24:0] s;
      w = 17'h10000 - {1'b0, f};
      s = w * a + f * b;
      return s[23:16];
   endfunction

   assign head      = pop_data;
   assign pop_ready = (state_ff == S_IDLE);
   assign ram_we    = (state_ff == S_IDLE) && pop_valid && !head.is_read;

   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            rsel = head.r0;
            csel = head.ca;
         end
         S_B0: begin
            rsel = ent_ff.r0;
            csel = ent_ff.cb;
         end
         S_A1: begin
            rsel = ent_ff.r1;
            csel = ent_ff.ca;
         end
         S_B1: begin
            rsel = ent_ff.r1;
            csel = ent_ff.cb;
         end
         default: begin
            rsel = ent_ff.r0;
            csel = ent_ff.ca;
         end
      endcase
   end

   assign ram_addr = AW'(rsel) * AW'(MAX_IN_WIDTH) + AW'(csel);

   rsz_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_IN_WIDTH * MAX_IN_HEIGHT)
   ) u_frame (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (head.pixel),
      .rdata (ram_rdata)
   );

   // horizontal blend of the held left pixel and the right pixel on the read port
   always_comb begin
      for (int c = 0; c < rsz_pkg::CHANNELS; c++) begin
         hb[c*8 +: 8] = hblend(p0_ff[c*8 +: 8], ram_rdata[c*8 +: 8], ent_ff.dx);
      end
   end

   // vertical blend, two truncated terms wrapping at eight bits
   assign wy = 17'h10000 - {1'b0, ent_ff.dy};

   always_comb begin
      logic [24:0] t1;
      logic [24:0] t2;
      for (int c = 0; c < rsz_pkg::CHANNELS; c++) begin
         t1 = wy * h0_ff[c*8 +: 8];
         t2 = ent_ff.dy * h1_ff[c*8 +: 8];
         vb[c*8 +: 8] = t1[23:16] + (ent_ff.second ? t2[23:16] : 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_V && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (pop_valid) begin
                  ent_ff <= head;
                  if (head.is_read) begin
                     state_ff <= head.in_range ? S_B0 : S_V;
                  end
               end
            end
            S_B0: begin
               p0_ff    <= ram_rdata;
               state_ff <= S_A1;
            end
            S_A1: begin
               h0_ff    <= hb;
               state_ff <= S_B1;
            end
            S_B1: begin
               p0_ff    <= ram_rdata;
               state_ff <= S_H1;
            end
            S_H1: begin
               h1_ff    <= hb;
               state_ff <= S_V;
            end
            S_V: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_in_range_ff <= ent_ff.in_range;
                  rsp_pix_ff      <= ent_ff.in_range ? vb : '0;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_in_range  = rsp_in_range_ff;
   assign rsp_out_blue  = rsp_pix_ff[7:0];
   assign rsp_out_green = rsp_pix_ff[15:8];
   assign rsp_out_red   = rsp_pix_ff[23:16];

endmodule

FILE: sv/bilinear_image_resize_core.sv
// Bilinear resize of a three-channel 8-bit image held in an on-chip frame store.
// An item with mode 0 loads one source pixel, with mode 1 it asks for one output
// pixel and returns one result item; loads outside the source size are dropped.
// The front end takes one item a cycle while the queue has room, works out
// positions and weights, and queues the item (four entries); the back end takes
// a load in S_IDLE; a read passes S_IDLE, S_B0, S_A1 and S_B1, which read the
// source pixels in turn through the frame memory's single port, then S_H1 and
// S_V, which finish the blend and fill the output register. Reads outside the
// output size skip to S_V and return zero samples with in_range low. Every source
// pixel a read uses must have been loaded; the frame store has no reset. The user
// writes size and step registers only while no item is in flight (not enforced).
module bilinear_image_resize_core #(
   parameter int MAX_IN_WIDTH  = rsz_pkg::DEF_MAX_IN_WIDTH,
   parameter int MAX_IN_HEIGHT = rsz_pkg::DEF_MAX_IN_HEIGHT,
   parameter int MAX_OUT_SIDE  = rsz_pkg::DEF_MAX_OUT_SIDE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [25:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [9:0]  req_row,
   input  logic [9:0]  req_col,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_red,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_red,
   output logic        rsp_in_range
);

   localparam int XW      = $clog2(MAX_IN_WIDTH);
   localparam int YW      = $clog2(MAX_IN_HEIGHT);
   localparam int ENTRY_W = rsz_pkg::entry_width(XW, YW);

   rsz_pkg::cfg_type   cfg_ff, cfg_in;
   logic               q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
   logic [ENTRY_W-1:0] q_push_data, q_pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rsz_pkg::CSR_IN_WIDTH:   cfg_in.in_width   = csr_data[10:0];
            rsz_pkg::CSR_IN_HEIGHT:  cfg_in.in_height  = csr_data[7:0];
            rsz_pkg::CSR_OUT_WIDTH:  cfg_in.out_width  = csr_data[10:0];
            rsz_pkg::CSR_OUT_HEIGHT: cfg_in.out_height = csr_data[10:0];
            rsz_pkg::CSR_X_STEP:     cfg_in.x_step     = csr_data;
            rsz_pkg::CSR_Y_STEP:     cfg_in.y_step     = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_width   <= 11'd1;
         cfg_ff.in_height  <= 8'd1;
         cfg_ff.out_width  <= 11'd1;
         cfg_ff.out_height <= 11'd1;
         cfg_ff.x_step     <= rsz_pkg::STEP_RESET;
         cfg_ff.y_step     <= rsz_pkg::STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rsz_front #(
      .MAX_IN_WIDTH  (MAX_IN_WIDTH),
      .MAX_IN_HEIGHT (MAX_IN_HEIGHT),
      .MAX_OUT_SIDE  (MAX_OUT_SIDE),
      .ENTRY_W       (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_blue   (req_blue),
      .req_green  (req_green),
      .req_red    (req_red),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data)
   );

   rsz_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (rsz_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   rsz_back #(
      .MAX_IN_WIDTH  (MAX_IN_WIDTH),
      .MAX_IN_HEIGHT (MAX_IN_HEIGHT),
      .ENTRY_W       (ENTRY_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (q_pop_valid),
      .pop_ready     (q_pop_ready),
      .pop_data      (q_pop_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_green (rsp_out_green),
      .rsp_out_red   (rsp_out_red),
      .rsp_in_range  (rsp_in_range)
   );

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |->
         rsp_out_blue == 8'd0 && rsp_out_green == 8'd0 && rsp_out_red == 8'd0)
      else $error("out-of-range item carries nonzero samples");

   a_queue_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_push_valid && !q_push_ready |-> !req_ready)
      else $error("item taken while queue is full");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int FRAME_W = rsz_pkg::DEF_MAX_IN_WIDTH;
   localparam int FRAME_H = rsz_pkg::DEF_MAX_IN_HEIGHT;
   localparam int OUT_SIDE = rsz_pkg::DEF_MAX_OUT_SIDE;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_ITEMS = 60;
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       in_range;
   } pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [25:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = MODE_LOAD;
   logic [9:0]  req_row = '0;
   logic [9:0]  req_col = '0;
   logic [7:0]  req_blue = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_red = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_blue;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_red;
   logic        rsp_in_range;

   rsz_pkg::cfg_type cfg = '{in_width: 11'd1, in_height: 8'd1, out_width: 11'd1,
                             out_height: 11'd1, x_step: rsz_pkg::STEP_RESET,
                             y_step: rsz_pkg::STEP_RESET};
   logic [23:0] source_px [FRAME_W * FRAME_H];
   bit          source_loaded [FRAME_W * FRAME_H];
   pixel_type   expected_px [$];
   int          failures = 0;
   int          items_taken = 0;
   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   logic        rsp_hold = 1'b0;

   bilinear_image_resize_core i_dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
                                         input int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned eff_in_w();
      return clamp(cfg.in_width, 1, FRAME_W);
   endfunction

   function automatic int unsigned eff_in_h();
      return clamp(cfg.in_height, 1, FRAME_H);
   endfunction

   function automatic int unsigned eff_out_w();
      return clamp(cfg.out_width, 0, OUT_SIDE);
   endfunction

   function automatic int unsigned eff_out_h();
      return clamp(cfg.out_height, 0, OUT_SIDE);
   endfunction

   function automatic logic [25:0] fitted_step(input int unsigned src, input int unsigned dst);
      if (dst <= 1) return '0;
      return 26'(((src - 1) << 16) / (dst - 1));
   endfunction

   // source index pair and Q16 fraction for one output coordinate
   function automatic void step_position(input int unsigned idx, input logic [25:0] step,
                                         input int unsigned last, output int unsigned lo,
                                         output int unsigned hi, output int unsigned frac);
      longint unsigned pos;
      longint unsigned ipos;
      pos = longint'(idx) * longint'(step);
      frac = 32'(pos[15:0]);
      ipos = pos >> 16;
      lo = (ipos > last) ? last : 32'(ipos);
      hi = (ipos + 1 > last) ? last : 32'(ipos + 1);
   endfunction

   function automatic logic [7:0] src_channel(input int unsigned srow, input int unsigned scol,
                                              input int ch);
      return source_px[srow * FRAME_W + scol][8 * ch +: 8];
   endfunction

   function automatic logic [7:0] row_blend(input int unsigned srow, input int unsigned col,
                                            input int ch);
      int unsigned     inw;
      int unsigned     c0;
      int unsigned     c1;
      int unsigned     dx;
      longint unsigned acc;
      inw = eff_in_w();
      if (col + 1 == eff_out_w() || inw == 1) return src_channel(srow, inw - 1, ch);
      step_position(col, cfg.x_step, inw - 1, c0, c1, dx);
      acc = longint'(65536 - dx) * src_channel(srow, c0, ch) +
            longint'(dx) * src_channel(srow, c1, ch);
      return acc[23:16];
   endfunction

   function automatic pixel_type resized_pixel(input int unsigned row, input int unsigned col);
      pixel_type       px;
      int unsigned     inh;
      int unsigned     r0;
      int unsigned     r1;
      int unsigned     dy;
      bit              second;
      longint unsigned acc;
      logic [7:0]      chan [3];
      if (row >= eff_out_h() || col >= eff_out_w()) return '0;
      inh = eff_in_h();
      step_position(row, cfg.y_step, inh - 1, r0, r1, dy);
      second = !(row + 1 == eff_out_h() || inh == 1);
      for (int ch = 0; ch < rsz_pkg::CHANNELS; ch++) begin
         acc = (longint'(65536 - dy) * row_blend(r0, col, ch)) >> 16;
         if (second) acc += (longint'(dy) * row_blend(r1, col, ch)) >> 16;
         chan[ch] = acc[7:0];
      end
      px.blue = chan[0];
      px.green = chan[1];
      px.red = chan[2];
      px.in_range = 1'b1;
      return px;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_px.size() == 0) begin
            $error("result item with no read outstanding");
            failures++;
         end else begin
            want = expected_px.pop_front();
            check_field("out_blue", want.blue, rsp_out_blue);
            check_field("out_green", want.green, rsp_out_green);
            check_field("out_red", want.red, rsp_out_red);
            check_field("in_range", 8'(want.in_range), 8'(rsp_in_range));
         end
      end
   end

   task automatic send_item(input logic mode, input logic [9:0] row, input logic [9:0] col,
                            input logic [7:0] blue, input logic [7:0] green,
                            input logic [7:0] red);
      int unsigned addr;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_row <= row;
      req_col <= col;
      req_blue <= blue;
      req_green <= green;
      req_red <= red;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (mode == MODE_LOAD) begin
         if (row < eff_in_h() && col < eff_in_w()) begin
            addr = row * FRAME_W + col;
            source_px[addr] = {red, green, blue};
            source_loaded[addr] = 1'b1;
            items_taken++;
         end
      end else begin
         expected_px.push_back(resized_pixel(row, col));
         items_taken++;
      end
   endtask

   // every source pixel the read may touch is loaded first
   task automatic fitted_read(input int unsigned row, input int unsigned col);
      int unsigned rows [2];
      int unsigned cols [3];
      int unsigned frac;
      if (row < eff_out_h() && col < eff_out_w()) begin
         step_position(row, cfg.y_step, eff_in_h() - 1, rows[0], rows[1], frac);
         step_position(col, cfg.x_step, eff_in_w() - 1, cols[0], cols[1], frac);
         cols[2] = eff_in_w() - 1;
         foreach (rows[i]) begin
            foreach (cols[j]) begin
               if (!source_loaded[rows[i] * FRAME_W + cols[j]])
                  send_item(MODE_LOAD, 10'(rows[i]), 10'(cols[j]), 8'($urandom),
                            8'($urandom), 8'($urandom));
            end
         end
      end
      send_item(MODE_READ, 10'(row), 10'(col), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input rsz_pkg::csr_index_type idx, input logic [25:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         rsz_pkg::CSR_IN_WIDTH:   cfg.in_width = data[10:0];
         rsz_pkg::CSR_IN_HEIGHT:  cfg.in_height = data[7:0];
         rsz_pkg::CSR_OUT_WIDTH:  cfg.out_width = data[10:0];
         rsz_pkg::CSR_OUT_HEIGHT: cfg.out_height = data[10:0];
         rsz_pkg::CSR_X_STEP:     cfg.x_step = data;
         rsz_pkg::CSR_Y_STEP:     cfg.y_step = data;
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned in_w, input int unsigned in_h,
                            input int unsigned out_w, input int unsigned out_h,
                            input logic [25:0] xs, input logic [25:0] ys);
      write_reg(rsz_pkg::CSR_IN_WIDTH, 26'(in_w));
      write_reg(rsz_pkg::CSR_IN_HEIGHT, 26'(in_h));
      write_reg(rsz_pkg::CSR_OUT_WIDTH, 26'(out_w));
      write_reg(rsz_pkg::CSR_OUT_HEIGHT, 26'(out_h));
      write_reg(rsz_pkg::CSR_X_STEP, xs);
      write_reg(rsz_pkg::CSR_Y_STEP, ys);
   endtask

   task automatic configure_fitted(input int unsigned in_w, input int unsigned in_h,
                                   input int unsigned out_w, input int unsigned out_h);
      configure(in_w, in_h, out_w, out_h,
                fitted_step(clamp(in_w, 1, FRAME_W), clamp(out_w, 0, OUT_SIDE)),
                fitted_step(clamp(in_h, 1, FRAME_H), clamp(out_h, 0, OUT_SIDE)));
   endtask

   task automatic test_reset_state();
      send_item(MODE_LOAD, 10'd0, 10'd0, 8'hFF, 8'h00, 8'hA5);
      send_item(MODE_LOAD, 10'd1, 10'd0, 8'h12, 8'h34, 8'h56);
      send_item(MODE_LOAD, 10'd0, 10'd1023, 8'h00, 8'hFF, 8'h00);
      fitted_read(0, 0);
      fitted_read(0, 1);
      fitted_read(1023, 1023);
   endtask

   task automatic test_size_limits();
      configure_fitted(2047, 255, 2047, 2047);
      send_item(MODE_LOAD, 10'd127, 10'd1023, 8'hFF, 8'hFF, 8'hFF);
      send_item(MODE_LOAD, 10'd126, 10'd1023, 8'h00, 8'h00, 8'h00);
      send_item(MODE_LOAD, 10'd1023, 10'd1023, 8'h5A, 8'h5A, 8'h5A);
      fitted_read(1023, 1023);
      fitted_read(0, 0);
      fitted_read(1022, 1022);
      fitted_read(512, 511);
   endtask

   task automatic test_degenerate_sizes();
      configure_fitted(0, 0, 5, 3);
      fitted_read(0, 0);
      fitted_read(1, 2);
      fitted_read(2, 4);
      fitted_read(3, 0);
      fitted_read(0, 5);
      write_reg(rsz_pkg::CSR_OUT_WIDTH, 26'd0);
      fitted_read(0, 0);
   endtask

   task automatic test_oversized_steps();
      configure(4, 3, 8, 8, 26'h3FFFFFF, 26'h3FFFFFF);
      fitted_read(1, 1);
      fitted_read(6, 6);
      fitted_read(7, 0);
      fitted_read(0, 7);
      configure(3, 3, 7, 5, 26'h000FFFF, 26'h0008001);
      fitted_read(1, 1);
      fitted_read(3, 5);
      fitted_read(4, 6);
   endtask

   // receiver held off long enough for the block to fill and stall its input
   task automatic test_backpressure();
      configure_fitted(4, 4, 9, 9);
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         repeat (40) fitted_read($urandom_range(8), $urandom_range(8));
      join
   endtask

   function automatic int unsigned pick_size(input int unsigned typical, input int unsigned top);
      case ($urandom_range(19))
         0: return 0;
         1: return 1;
         2, 3: return $urandom_range(top / 2, top);
         default: return $urandom_range(2, typical);
      endcase
   endfunction

   task automatic test_random(input int send_pct, input int take_pct, input int phases);
      int unsigned in_w;
      int unsigned in_h;
      int unsigned out_w;
      int unsigned out_h;
      logic [25:0] xs;
      logic [25:0] ys;
      int          start;
      int          pick;
      req_idle_pct = send_pct;
      rsp_idle_pct <= take_pct;
      repeat (phases) begin
         in_w = pick_size(12, 2047);
         in_h = pick_size(8, 255);
         out_w = pick_size(16, 2047);
         out_h = pick_size(16, 2047);
         xs = fitted_step(clamp(in_w, 1, FRAME_W), clamp(out_w, 0, OUT_SIDE));
         ys = fitted_step(clamp(in_h, 1, FRAME_H), clamp(out_h, 0, OUT_SIDE));
         if ($urandom_range(3) == 0) xs = 26'($urandom);
         if ($urandom_range(3) == 0) ys = 26'($urandom);
         configure(in_w, in_h, out_w, out_h, xs, ys);
         start = items_taken;
         while (items_taken - start < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 60 && eff_out_w() > 0 && eff_out_h() > 0)
               fitted_read($urandom_range(eff_out_h() - 1), $urandom_range(eff_out_w() - 1));
            else if (pick < 80)
               send_item(MODE_LOAD, 10'($urandom_range(eff_in_h() - 1)),
                         10'($urandom_range(eff_in_w() - 1)), 8'($urandom), 8'($urandom),
                         8'($urandom));
            else if (pick < 93)
               fitted_read($urandom_range(1023), $urandom_range(1023));
            else
               send_item(MODE_LOAD, 10'($urandom), 10'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_size_limits();
      test_degenerate_sizes();
      test_oversized_steps();
      test_backpressure();
      test_random(17, 61, 10);
      test_random(61, 17, 10);
      test_random(0, 0, 10);
      drain();
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
